// File: src/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg: shared types, constants and helpers for the stereo biquad filter
// Fixed-point formats, register map, queue item layout and saturation logic.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int CHANNELS   = 2;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Datapath formats
  localparam int GUARD_BITS = 16;
  localparam int DELAY_W    = SAMPLE_W + GUARD_BITS;
  localparam int PROD_SHIFT = COEF_W - 20;
  localparam int MUL_W      = COEF_W + SAMPLE_W;
  localparam int PROD_W     = MUL_W - PROD_SHIFT;
  localparam int ACC_W      = PROD_W + 2;
  localparam int YPRE_W     = ACC_W - GUARD_BITS;

  // Stream payload
  localparam int TDATA_W    = SAMPLE_W * CHANNELS;

  // Configuration port
  localparam int NUM_REGS   = 5;
  localparam int ADDR_W     = 5;
  localparam int IDX_W      = ADDR_W - 2;
  localparam int DATA_W     = 32;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << (COEF_W - 4);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [IDX_W-1:0] {
    REG_FF_GAIN_0 = 3'd0,
    REG_FF_GAIN_1 = 3'd1,
    REG_FF_GAIN_2 = 3'd2,
    REG_FB_GAIN_1 = 3'd3,
    REG_FB_GAIN_2 = 3'd4
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [DELAY_W-1:0]  delay_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [YPRE_W-1:0]   ypre_t;
  typedef sample_t [CHANNELS-1:0]     smp_vec_t;

  typedef struct packed {
    coef_t ff0;
    coef_t ff1;
    coef_t ff2;
    coef_t fb1;
    coef_t fb2;
  } coef_set_t;

  typedef struct packed {
    logic     last;
    smp_vec_t smp;
  } item_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam delay_t  DELAY_MAX  = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam delay_t  DELAY_MIN  = {1'b1, {(DELAY_W-1){1'b0}}};

  function automatic logic fits_sample(input ypre_t v);
    logic [YPRE_W-SAMPLE_W:0] top;
    top = v[YPRE_W-1:SAMPLE_W-1];
    return (&top) || (~|top);
  endfunction

  function automatic sample_t sat_sample(input ypre_t v);
    sample_t r;
    if (fits_sample(v)) begin
      r = v[SAMPLE_W-1:0];
    end else begin
      r = v[YPRE_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    return r;
  endfunction

  function automatic logic fits_delay(input acc_t v);
    logic [ACC_W-DELAY_W:0] top;
    top = v[ACC_W-1:DELAY_W-1];
    return (&top) || (~|top);
  endfunction

  function automatic delay_t sat_delay(input acc_t v);
    delay_t r;
    if (fits_delay(v)) begin
      r = v[DELAY_W-1:0];
    end else begin
      r = v[ACC_W-1] ? DELAY_MIN : DELAY_MAX;
    end
    return r;
  endfunction

endpackage

// File: src/sbq_regs.sv
// ----------------------------------------------------------------------------
// sbq_regs: coefficient register file
// APB-style write/read access to the five shared filter coefficients.
// ----------------------------------------------------------------------------
module sbq_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sbq_pkg::ADDR_W-1:0] paddr,
  input  logic [sbq_pkg::DATA_W-1:0] pwdata,
  output logic [sbq_pkg::DATA_W-1:0] prdata,
  output sbq_pkg::coef_set_t        coefs
);
  import sbq_pkg::*;

  coef_set_t coefs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign coefs = coefs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.ff0 <= coef_t'(COEF_ONE);
      coefs_r.ff1 <= '0;
      coefs_r.ff2 <= '0;
      coefs_r.fb1 <= '0;
      coefs_r.fb2 <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_FF_GAIN_0: coefs_r.ff0 <= coef_t'(pwdata[COEF_W-1:0]);
        REG_FF_GAIN_1: coefs_r.ff1 <= coef_t'(pwdata[COEF_W-1:0]);
        REG_FF_GAIN_2: coefs_r.ff2 <= coef_t'(pwdata[COEF_W-1:0]);
        REG_FB_GAIN_1: coefs_r.fb1 <= coef_t'(pwdata[COEF_W-1:0]);
        REG_FB_GAIN_2: coefs_r.fb2 <= coef_t'(pwdata[COEF_W-1:0]);
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FF_GAIN_0: prdata = DATA_W'(coefs_r.ff0);
      REG_FF_GAIN_1: prdata = DATA_W'(coefs_r.ff1);
      REG_FF_GAIN_2: prdata = DATA_W'(coefs_r.ff2);
      REG_FB_GAIN_1: prdata = DATA_W'(coefs_r.fb1);
      REG_FB_GAIN_2: prdata = DATA_W'(coefs_r.fb2);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: src/sbq_front.sv
// ----------------------------------------------------------------------------
// sbq_front: input side and item queue
// Accept stream items and hold them in a short queue for the filter engine.
// ----------------------------------------------------------------------------
module sbq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sbq_pkg::item_t in_item,
  output logic           in_ready,
  output logic           q_valid,
  output sbq_pkg::item_t q_item,
  input  logic           q_pop
);
  import sbq_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/sbq_engine.sv
// ----------------------------------------------------------------------------
// sbq_engine: filter sequencer with one shared multiplier
// Run each channel through the biquad in six steps and register the result.
// ----------------------------------------------------------------------------
module sbq_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  sbq_pkg::coef_set_t coefs,
  input  logic               q_valid,
  input  sbq_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sbq_pkg::smp_vec_t  out_smp,
  output logic               out_clip,
  output logic               out_last
);
  import sbq_pkg::*;

  // P0..P4 each issue one multiply and P5 none; each product is consumed a step later
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5
  } state_t;

  state_t          state_r;
  logic [CH_W-1:0] ch_r;
  item_t           item_r;
  prod_t           prod_r;
  acc_t            acc_r;
  sample_t         y_r;
  sample_t         res_r [CHANNELS];
  delay_t          z1_r [CHANNELS];
  delay_t          z2_r [CHANNELS];
  logic            clip_r;
  logic            out_valid_r;
  smp_vec_t        out_smp_r;
  logic            out_clip_r;
  logic            out_last_r;

  logic                    last_ch;
  logic                    out_free;
  logic                    finish;
  sample_t                 x_cur;
  coef_t                   coef_sel;
  sample_t                 samp_sel;
  logic signed [MUL_W-1:0] mul_full;
  prod_t                   prod_nxt;
  acc_t                    acc_y;
  ypre_t                   y_pre;
  acc_t                    acc_z2;

  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == ST_P5) && last_ch && out_free;
  assign q_pop    = q_valid && ((state_r == ST_IDLE) || finish);
  assign x_cur    = item_r.smp[ch_r];

  always_comb begin
    unique case (state_r)
      ST_P0:   begin coef_sel = coefs.ff0; samp_sel = x_cur; end
      ST_P1:   begin coef_sel = coefs.ff1; samp_sel = x_cur; end
      ST_P2:   begin coef_sel = coefs.fb1; samp_sel = y_r;   end
      ST_P3:   begin coef_sel = coefs.ff2; samp_sel = x_cur; end
      ST_P4:   begin coef_sel = coefs.fb2; samp_sel = y_r;   end
      default: begin coef_sel = '0;        samp_sel = '0;    end
    endcase
  end

  assign mul_full = MUL_W'(coef_sel) * MUL_W'(samp_sel);
  assign prod_nxt = PROD_W'(mul_full >>> PROD_SHIFT);
  assign acc_y    = ACC_W'(prod_r) + ACC_W'(z1_r[ch_r]);
  assign y_pre    = acc_y[ACC_W-1:GUARD_BITS];
  assign acc_z2   = acc_r - ACC_W'(prod_r);

  assign out_valid = out_valid_r;
  assign out_smp   = out_smp_r;
  assign out_clip  = out_clip_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        z1_r[c] <= '0;
        z2_r[c] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: ;
        ST_P0: begin
          prod_r  <= prod_nxt;
          state_r <= ST_P1;
        end
        ST_P1: begin
          prod_r  <= prod_nxt;
          y_r     <= sat_sample(y_pre);
          clip_r  <= clip_r | !fits_sample(y_pre);
          state_r <= ST_P2;
        end
        ST_P2: begin
          prod_r  <= prod_nxt;
          acc_r   <= ACC_W'(prod_r) + ACC_W'(z2_r[ch_r]);
          state_r <= ST_P3;
        end
        ST_P3: begin
          prod_r  <= prod_nxt;
          acc_r   <= acc_r - ACC_W'(prod_r);
          state_r <= ST_P4;
        end
        ST_P4: begin
          prod_r     <= prod_nxt;
          z1_r[ch_r] <= sat_delay(acc_r);
          clip_r     <= clip_r | !fits_delay(acc_r);
          acc_r      <= ACC_W'(prod_r);
          state_r    <= ST_P5;
        end
        ST_P5: begin
          if (!last_ch) begin
            z2_r[ch_r]  <= sat_delay(acc_z2);
            clip_r      <= clip_r | !fits_delay(acc_z2);
            res_r[ch_r] <= y_r;
            ch_r        <= ch_r + CH_W'(1);
            state_r     <= ST_P0;
          end else if (out_free) begin
            z2_r[ch_r]  <= sat_delay(acc_z2);
            out_valid_r <= 1'b1;
            out_clip_r  <= clip_r | !fits_delay(acc_z2);
            out_last_r  <= item_r.last;
            for (int c = 0; c < CHANNELS; c++) begin
              out_smp_r[c] <= (c == CHANNELS - 1) ? y_r : res_r[c];
            end
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // Load the next item; overrides the step above when a frame just finished
      if (q_pop) begin
        item_r  <= q_item;
        ch_r    <= '0;
        clip_r  <= 1'b0;
        state_r <= ST_P0;
      end
    end
  end

endmodule

// File: src/stereo_biquad_lowpass.sv
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass: stereo second-order IIR section, transposed DF-II
// Top level: coefficient registers, input queue and filter engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   stream slave: one stereo frame per item, tdata = {right, left}
//          (signed Q1.23 each), tlast marks the last frame of a host block.
//   out_*  stream master: filtered frame per item, tdata = {right, left},
//          tuser = clip flag, tlast = copy of the input marker.
//   cfg_*  APB-style port: five Q3.28 coefficients at byte addresses 0x00
//          (ff_gain_0) through 0x10 (fb_gain_2); write only while idle.
// Sharing: one 32x24 multiplier is shared by all ten products of a frame
//   (five per channel, one per cycle), so the engine filters one frame at
//   a time while the queue keeps taking in the following frames.
// Path: an accepted frame is written into the queue, runs through P0..P5
//   for each channel in the engine and lands in the output register.
// Reset: coefficients return to passthrough (ff_gain_0 = 1.0, rest 0),
//   all delay terms clear, the queue empties and out_tvalid drops.
// Stall: a finished frame waits in the output register; a two-entry queue
//   keeps taking input while the engine works or waits, and in_tready
//   drops only when the queue is full.
// ----------------------------------------------------------------------------
module stereo_biquad_lowpass (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sbq_pkg::TDATA_W-1:0] in_tdata,   // [23:0] left_sample, [47:24] right_sample
  input  logic                        in_tlast,
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sbq_pkg::TDATA_W-1:0] out_tdata,  // [23:0] left_result, [47:24] right_result
  output logic                        out_tuser,  // [0] clip_flag
  output logic                        out_tlast,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sbq_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [sbq_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [sbq_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import sbq_pkg::*;

  coef_set_t coefs;
  item_t     in_item;
  item_t     q_item;
  logic      q_valid;
  logic      q_pop;
  smp_vec_t  out_smp;

  assign cfg_pready = 1'b1;

  // Pack the incoming frame; left sits in the low bits
  assign in_item.smp  = smp_vec_t'(in_tdata);
  assign in_item.last = in_tlast;

  sbq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .coefs   (coefs)
  );

  // Front: hold accepted frames until the engine is free
  sbq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .in_ready (in_tready),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back: filter both channels and park the result in the output register
  sbq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .coefs     (coefs),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_smp   (out_smp),
    .out_clip  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_smp);

endmodule

// File: src/sbq_checker.sv
// ----------------------------------------------------------------------------
// sbq_checker: port-level checks for the stereo biquad filter
// Reset behavior, config port readiness and output stream stability.
// ----------------------------------------------------------------------------
module sbq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [sbq_pkg::TDATA_W-1:0] out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast,
  input logic                        cfg_pready
);

  // After reset nothing is pending and the queue has room
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output pending or input blocked after reset");

  // Config port never inserts wait states
  a_cfg_ready: assert property (@(posedge clk) cfg_pready)
    else $error("cfg_pready dropped");

  // A stalled result is neither withdrawn nor altered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid withdrawn under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output payload changed under stall");

endmodule

bind stereo_biquad_lowpass sbq_checker u_sbq_checker (.*);

// File: tb/tb_stereo_biquad_lowpass.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_biquad_lowpass: self-checking bench for the stereo biquad section
// Loads coefficient sets over the config port and streams stereo frames
// through the filter. A fixed-point predictor tracks the delay terms of both
// channels, and every result frame is compared field by field.
// ----------------------------------------------------------------------------
module tb_stereo_biquad_lowpass;
  import sbq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // well above the longest legal quiet spell
  localparam int LONG_HOLD_AT   = 200;   // accepted frames before the long back-pressure
  localparam int LONG_HOLD_LEN  = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;    // idle time before the final check for missing results
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_FRAMES   = 80;
  localparam int IDX_SPAN       = 1 << IDX_W;

  localparam coef_t COEF_MAX = 32'sh7fff_ffff;
  localparam coef_t COEF_MIN = 32'sh8000_0000;

  // Butterworth-like low-pass near fs/10, Q3.28
  localparam coef_t LP_B0 = 32'sd18119393;
  localparam coef_t LP_B1 = 32'sd36238786;
  localparam coef_t LP_A1 = -32'sd306823727;
  localparam coef_t LP_A2 = 32'sd110810156;

  typedef struct {
    sample_t left_smp;
    sample_t right_smp;
    logic    blk_end;
  } stereo_frame_t;

  typedef struct {
    sample_t left_res;
    sample_t right_res;
    logic    clip;
    logic    blk_end;
  } filtered_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata = '0;   // [23:0] left_sample, [47:24] right_sample
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;       // [23:0] left_result, [47:24] right_result
  logic                out_tuser;       // [0] clip_flag
  logic                out_tlast;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Predictor state: coefficient bank and per-channel delay terms
  coef_t  coef_bank [NUM_REGS];
  longint delay1_st [CHANNELS];
  longint delay2_st [CHANNELS];

  stereo_frame_t   frames_to_send [$];
  filtered_frame_t frames_due [$];
  stereo_frame_t   next_frame;
  filtered_frame_t want;

  logic in_fire = 1'b0;
  logic steady = 1'b0;     // no gaps on either side while set
  int   send_gap = 0;
  int   hold_cnt = 0;
  bit   long_hold_done = 1'b0;
  int   idle_cycles = 0;
  int   n_frames_in = 0;
  int   n_frames_out = 0;
  int   n_clipped = 0;
  int   n_blk_end = 0;
  int   n_settings = 0;
  int   n_err = 0;

  stereo_biquad_lowpass u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point filter arithmetic
  // --------------------------------------------------------------------------

  // Product of a Q3.28 coefficient and a sample, floored into the delay format.
  function automatic longint scale_prod(input longint c, input longint x);
    return (c * x) >>> PROD_SHIFT;
  endfunction

  // Saturate to a signed width and note any clipping.
  function automatic longint clamp(input longint v, input int w, inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Run one stereo frame through both channels and queue the filtered frame.
  task automatic filter_frame(input sample_t l, input sample_t r, input logic blk_end);
    filtered_frame_t res;
    logic   clip;
    longint x;
    longint y;
    longint z1;
    longint z2;
    clip = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      x  = (ch == 0) ? l : r;
      y  = clamp((scale_prod(coef_bank[REG_FF_GAIN_0], x) + delay1_st[ch]) >>> GUARD_BITS,
                 SAMPLE_W, clip);
      // feed back the saturated output, not the raw sum
      z1 = scale_prod(coef_bank[REG_FF_GAIN_1], x) - scale_prod(coef_bank[REG_FB_GAIN_1], y)
           + delay2_st[ch];
      z2 = scale_prod(coef_bank[REG_FF_GAIN_2], x) - scale_prod(coef_bank[REG_FB_GAIN_2], y);
      delay1_st[ch] = clamp(z1, DELAY_W, clip);
      delay2_st[ch] = clamp(z2, DELAY_W, clip);
      if (ch == 0) begin
        res.left_res = sample_t'(y);
      end else begin
        res.right_res = sample_t'(y);
      end
    end
    res.clip    = clip;
    res.blk_end = blk_end;
    frames_due.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Half full-range values, the rest quiet signals and rail values.
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom);
    if (r < 8) return sample_t'(int'($urandom_range(0, 8191)) - 4096);
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic coef_t mild_coef(input int span_log2);
    return coef_t'(int'($urandom_range(0, 1 << span_log2)) - (1 << (span_log2 - 1)));
  endfunction

  task automatic push_frame(input sample_t l, input sample_t r, input logic blk_end);
    stereo_frame_t f;
    f.left_smp  = l;
    f.right_smp = r;
    f.blk_end   = blk_end;
    frames_to_send.push_back(f);
  endtask

  task automatic push_random_frames(input int count);
    for (int i = 0; i < count; i++) begin
      push_frame(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
    end
  endtask

  // Setup cycle, then access cycle; the write lands when the slave is ready.
  task automatic cfg_write(input int idx, input coef_t val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'(idx * 4);
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    // unmapped indexes leave the bank alone
    if (idx < NUM_REGS) coef_bank[idx] = val;
  endtask

  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t a1, input coef_t a2);
    cfg_write(REG_FF_GAIN_0, b0);
    cfg_write(REG_FF_GAIN_1, b1);
    cfg_write(REG_FF_GAIN_2, b2);
    cfg_write(REG_FB_GAIN_1, a1);
    cfg_write(REG_FB_GAIN_2, a2);
    n_settings++;
  endtask

  // Hold until every queued frame went in and every result came back.
  task automatic wait_idle();
    while (frames_to_send.size() != 0 || in_tvalid || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: advance to the next frame once the current one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (frames_to_send.size() != 0) begin
        next_frame = frames_to_send.pop_front();
        in_tdata  <= {next_frame.right_smp, next_frame.left_smp};
        in_tlast  <= next_frame.blk_end;
        in_tvalid <= 1'b1;
        send_gap = steady ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls plus one long hold-off that fills the
  // block and pushes back on the input side
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!long_hold_done && n_frames_in >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      hold_cnt = pick_gap();
      out_tready <= (hold_cnt == 0);
      if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sample both handshakes at the rising edge: predict on input, check on
  // output against the oldest pending frame
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      filter_frame(sample_t'(in_tdata[SAMPLE_W-1:0]),
                   sample_t'(in_tdata[2*SAMPLE_W-1:SAMPLE_W]), in_tlast);
      n_frames_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_frames_out++;
      if (out_tuser) n_clipped++;
      if (out_tlast) n_blk_end++;
      if (frames_due.size() == 0) begin
        $display("%0t: result frame with none pending: tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
        n_err++;
      end else begin
        want = frames_due.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.left_res) begin
          $display("%0t: left_result expected %h, got %h",
                   $time, want.left_res, out_tdata[SAMPLE_W-1:0]);
          n_err++;
        end
        if (out_tdata[2*SAMPLE_W-1:SAMPLE_W] !== want.right_res) begin
          $display("%0t: right_result expected %h, got %h",
                   $time, want.right_res, out_tdata[2*SAMPLE_W-1:SAMPLE_W]);
          n_err++;
        end
        if (out_tuser !== want.clip) begin
          $display("%0t: clip_flag expected %b, got %b", $time, want.clip, out_tuser);
          n_err++;
        end
        if (out_tlast !== want.blk_end) begin
          $display("%0t: block_end_out expected %b, got %b", $time, want.blk_end, out_tlast);
          n_err++;
        end
      end
    end
  end

  // Drop the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles, %0d results pending",
               $time, idle_cycles, frames_due.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    coef_bank[REG_FF_GAIN_0] = COEF_ONE;
    coef_bank[REG_FF_GAIN_1] = '0;
    coef_bank[REG_FF_GAIN_2] = '0;
    coef_bank[REG_FB_GAIN_1] = '0;
    coef_bank[REG_FB_GAIN_2] = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      delay1_st[ch] = 0;
      delay2_st[ch] = 0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(posedge clk);

    // Reset coefficients pass samples straight through; hit the rails.
    n_settings++;
    push_frame('0, '0, 1'b0);
    push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    push_frame('1, sample_t'(1), 1'b1);
    push_frame(sample_t'(24'h123456), sample_t'(-24'sh123456), 1'b0);
    wait_idle();

    // Extreme coefficients drive both the outputs and the delay terms into
    // saturation, in both directions.
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    push_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    push_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    push_frame('0, '0, 1'b0);
    push_frame('0, '0, 1'b1);
    push_frame(sample_t'(1), '1, 1'b0);
    wait_idle();

    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    push_frame('1, '0, 1'b0);
    push_frame('0, '1, 1'b1);
    wait_idle();

    // All-zero coefficients: the outputs just drain the stored delay terms.
    // Writes to unmapped indexes must not land anywhere.
    load_coefs('0, '0, '0, '0, '0);
    for (int i = NUM_REGS; i < IDX_SPAN; i++) cfg_write(i, COEF_ONE);
    push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    push_frame('0, '0, 1'b1);
    push_frame('0, '0, 1'b0);
    push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    wait_idle();

    // Random phases; each reloads the coefficients, cycling through four kinds of set.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: load_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
        1: load_coefs(mild_coef(30), mild_coef(30), mild_coef(30), mild_coef(30),
                      mild_coef(30));
        2: load_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                      coef_t'($urandom), coef_t'($urandom));
        default: load_coefs(mild_coef(29), mild_coef(28), mild_coef(28), '0, '0);
      endcase
      steady = (ph == 3);
      push_random_frames(PHASE_FRAMES / 2);
      // Pause the sender once until the pipeline has fully drained.
      if (ph == 0) wait_idle();
      push_random_frames(PHASE_FRAMES - PHASE_FRAMES / 2);
      wait_idle();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d result frames never arrived", $time, frames_due.size());
      n_err++;
    end

    $display("Streamed %0d stereo frames under %0d coefficient settings; %0d results came back.",
             n_frames_in, n_settings, n_frames_out);
    $display("Of those, %0d had the clip flag set and %0d carried a block end; %0d mismatches.",
             n_clipped, n_blk_end, n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/sbq_pkg.sv
src/sbq_regs.sv
src/sbq_front.sv
src/sbq_engine.sv
src/stereo_biquad_lowpass.sv
src/sbq_checker.sv
tb/tb_stereo_biquad_lowpass.sv
